// ----- rtl/header_keyed_bit_message_decoder_macros.svh -----
// ----------------------------------------------------------------------------
// Header-keyed bit message decoder: assertion macros
// Concurrent checks sampled on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef HEADER_KEYED_BIT_MESSAGE_DECODER_MACROS_SVH
`define HEADER_KEYED_BIT_MESSAGE_DECODER_MACROS_SVH

// Same-cycle implication.
`define HKBMD_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define HKBMD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/hkbmd_pkg.sv -----
// ----------------------------------------------------------------------------
// hkbmd_pkg
// Types and codes shared by the header-keyed bit message decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package hkbmd_pkg;

    localparam logic [1:0] KIND_HDR_START = 2'd0;
    localparam logic [1:0] KIND_HDR_CHAR  = 2'd1;
    localparam logic [1:0] KIND_MSG_BIT   = 2'd2;

    localparam int LEN_FIELD_BITS = 3;

    typedef enum logic [3:0] {
        PH_DONE   = 4'b0001,
        PH_HEADER = 4'b0010,
        PH_LENGTH = 4'b0100,
        PH_KEY    = 4'b1000
    } phase_t;

    typedef struct packed {
        logic valid;
        logic hit;
        logic msg_end;
    } lookup_req_t;

endpackage

`default_nettype wire

// ----- rtl/hkbmd_table.sv -----
// ----------------------------------------------------------------------------
// hkbmd_table
// Key table memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module hkbmd_table #(
    parameter int DEPTH  = 247,
    parameter int ADDR_W = 8
) (
    input  wire logic              clk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [7:0]        wr_data,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [7:0]        rd_data
);

    logic [7:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ----- rtl/hkbmd_ctrl.sv -----
// ----------------------------------------------------------------------------
// hkbmd_ctrl
// Header load sequencing and bit-serial key parsing; issues table lookups.
// ----------------------------------------------------------------------------
`default_nettype none

module hkbmd_ctrl #(
    parameter int MAX_KEY_LENGTH = 7,
    parameter int DEPTH          = 247,
    parameter int ADDR_W         = 8,
    parameter int POS_W          = 8
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     item_en,
    input  wire logic [1:0]               kind,
    input  wire logic [7:0]               char_value,
    input  wire logic                     bit_value,
    output logic                          wr_en,
    output logic      [ADDR_W-1:0]        wr_addr,
    output logic      [7:0]               wr_data,
    output logic      [ADDR_W-1:0]        rd_addr,
    output hkbmd_pkg::lookup_req_t        req
);

    import hkbmd_pkg::*;

    localparam logic [2:0]       MAX_LEN   = 3'(MAX_KEY_LENGTH);
    localparam logic [POS_W-1:0] DEPTH_POS = POS_W'(DEPTH);

    phase_t           phase_reg, phase_next;
    logic [POS_W-1:0] load_pos_reg, load_pos_next;
    logic [6:0]       acc_reg, acc_next;
    logic [2:0]       cnt_reg, cnt_next;
    logic [2:0]       seg_len_reg, seg_len_next;

    phase_t     phase_eff;
    logic [6:0] acc_shift;
    logic [2:0] cnt_inc;
    logic [6:0] len_mask;
    logic [6:0] key_value;
    logic [8:0] key_idx;

    always_comb
    begin
        phase_eff = (phase_reg == PH_HEADER) ? PH_LENGTH : phase_reg;
        acc_shift = (phase_reg == PH_HEADER) ? {6'd0, bit_value}
                                             : {acc_reg[5:0], bit_value};
        cnt_inc   = (phase_reg == PH_HEADER) ? 3'd1 : cnt_reg + 3'd1;
        len_mask  = 7'((8'd1 << seg_len_reg) - 8'd1);
        key_value = acc_shift & len_mask;
        key_idx   = (9'd1 << seg_len_reg) - 9'(seg_len_reg) - 9'd1 + 9'(key_value);
        rd_addr   = key_idx[ADDR_W-1:0];
    end

    always_comb
    begin
        phase_next    = phase_reg;
        load_pos_next = load_pos_reg;
        acc_next      = acc_reg;
        cnt_next      = cnt_reg;
        seg_len_next  = seg_len_reg;
        wr_en         = 1'b0;
        wr_addr       = load_pos_reg[ADDR_W-1:0];
        wr_data       = char_value;
        req           = '0;

        if (item_en)
        begin
            case (kind)
                KIND_HDR_START:
                begin
                    phase_next    = PH_HEADER;
                    load_pos_next = '0;
                    acc_next      = '0;
                    cnt_next      = '0;
                    seg_len_next  = '0;
                end
                KIND_HDR_CHAR:
                begin
                    if (phase_reg == PH_HEADER && load_pos_reg < DEPTH_POS)
                    begin
                        wr_en         = 1'b1;
                        load_pos_next = load_pos_reg + 1'b1;
                    end
                end
                KIND_MSG_BIT:
                begin
                    if (phase_reg != PH_DONE)
                    begin
                        acc_next   = acc_shift;
                        cnt_next   = cnt_inc;
                        phase_next = phase_eff;
                        if (phase_eff == PH_LENGTH)
                        begin
                            if (cnt_inc == 3'(LEN_FIELD_BITS))
                            begin
                                acc_next = '0;
                                cnt_next = '0;
                                if (acc_shift[2:0] == 3'd0)
                                begin
                                    phase_next  = PH_DONE;
                                    req.valid   = 1'b1;
                                    req.msg_end = 1'b1;
                                end
                                else
                                begin
                                    seg_len_next = acc_shift[2:0];
                                    phase_next   = PH_KEY;
                                end
                            end
                        end
                        else if (cnt_inc == seg_len_reg)
                        begin
                            acc_next = '0;
                            cnt_next = '0;
                            if (key_value == len_mask)
                            begin
                                phase_next = PH_LENGTH;
                            end
                            else
                            begin
                                req.valid = 1'b1;
                                req.hit   = (seg_len_reg <= MAX_LEN)
                                            && (key_idx < 9'(load_pos_reg));
                            end
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_DONE;
            load_pos_reg <= '0;
            acc_reg      <= '0;
            cnt_reg      <= '0;
            seg_len_reg  <= '0;
        end
        else
        begin
            phase_reg    <= phase_next;
            load_pos_reg <= load_pos_next;
            acc_reg      <= acc_next;
            cnt_reg      <= cnt_next;
            seg_len_reg  <= seg_len_next;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/header_keyed_bit_message_decoder.sv -----
// ----------------------------------------------------------------------------
// header_keyed_bit_message_decoder
// Loads a key table from header characters, then decodes a serial bit stream.
// ----------------------------------------------------------------------------
// Input stream (s_*): tuser carries the item kind (header start, header
// character, message bit); tdata carries the character byte and the bit.
// Output stream (m_*): tdata is the decoded character, tlast marks the end of
// a message (a zero length field), with tdata zero.
// One input transfer per cycle is taken while the output keeps up. A result
// passes through the key table read stage and then the output register
// before it appears on m_tvalid.
// Items that cause no result only update the parser and the table.
// Reset empties the pipeline and leaves the decoder waiting for a header
// start; the table contents are unknown but every entry counts as unloaded.
// When m_tready is low the output register holds its result, one more result
// waits in the lookup stage, and s_tready drops once both are full.
// ----------------------------------------------------------------------------
`default_nettype none

`include "header_keyed_bit_message_decoder_macros.svh"

module header_keyed_bit_message_decoder #(
    parameter int MAX_KEY_LENGTH = 7
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,  // [7:0] char_value, [8] bit_value, [15:9] zero
    input  wire logic [1:0]  s_tuser,  // [1:0] kind
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [7:0]  m_tdata,  // [7:0] out_char
    output logic             m_tlast   // message_end
);

    import hkbmd_pkg::*;

    localparam int DEPTH  = (2 << MAX_KEY_LENGTH) - MAX_KEY_LENGTH - 2;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int POS_W  = $clog2(DEPTH + 1);

    logic              item_en;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [7:0]        wr_data;
    logic [ADDR_W-1:0] rd_addr;
    logic [7:0]        rd_data;
    lookup_req_t       req;

    logic       s1_valid_reg, s1_hit_reg, s1_end_reg;
    logic       out_valid_reg, out_end_reg;
    logic [7:0] out_char_reg;
    logic       s1_move;

    assign s_tready = !s1_valid_reg || !out_valid_reg || m_tready;
    assign item_en  = s_tvalid && s_tready;
    assign s1_move  = s1_valid_reg && (!out_valid_reg || m_tready);

    hkbmd_ctrl #(
        .MAX_KEY_LENGTH (MAX_KEY_LENGTH),
        .DEPTH          (DEPTH),
        .ADDR_W         (ADDR_W),
        .POS_W          (POS_W)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_en    (item_en),
        .kind       (s_tuser),
        .char_value (s_tdata[7:0]),
        .bit_value  (s_tdata[8]),
        .wr_en      (wr_en),
        .wr_addr    (wr_addr),
        .wr_data    (wr_data),
        .rd_addr    (rd_addr),
        .req        (req)
    );

    hkbmd_table #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_table (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (req.valid && req.hit),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (req.valid)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_move)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.valid)
        begin
            s1_hit_reg <= req.hit;
            s1_end_reg <= req.msg_end;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_move)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_move)
        begin
            out_char_reg <= s1_hit_reg ? rd_data : 8'd0;
            out_end_reg  <= s1_end_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_char_reg;
    assign m_tlast  = out_end_reg;

    `HKBMD_ASSERT_NOW(a_end_char_zero, m_tvalid && m_tlast, m_tdata == 8'd0,
        "message end carries a nonzero character")
    `HKBMD_ASSERT_NOW(a_full_stall_blocks, s1_valid_reg && out_valid_reg && !m_tready,
        !s_tready, "input taken while both result stages are stalled")
    `HKBMD_ASSERT_NEXT(a_req_enters_stage, req.valid, s1_valid_reg,
        "lookup request lost before the output stage")
    `HKBMD_ASSERT_NOW(a_req_needs_item, req.valid, item_en,
        "lookup request without an input transfer")

endmodule

`default_nettype wire
